/* src/rgblbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblbp_pkg
// Shared types, widths and helpers of the rgb to lbp 3x3 stream unit.
// ----------------------------------------------------------------------------
package rgblbp_pkg;

   // field and register widths
   localparam int COLOR_W      = 8;
   localparam int GRAY_W       = 8;
   localparam int CODE_W       = 8;
   localparam int FWIDTH_W     = 11;
   localparam int FHEIGHT_W    = 12;
   localparam int CSR_DATA_W   = 12;
   localparam int CSR_INDEX_W  = 1;
   // input row counter runs up to frame_height + 1 during the flush
   localparam int IN_ROW_W     = 13;

   localparam int DEF_MAX_WIDTH     = 1024;
   localparam int RESET_FRAME_WIDTH = 640;
   localparam int RESET_FRAME_HEIGHT = 480;

   // floor(x/3) for x < 2048 as (x * 683) >> 11
   localparam int DIV3_MUL   = 683;
   localparam int DIV3_SHIFT = 11;
   localparam int SUM_W      = COLOR_W + 2;
   localparam int PROD_W     = SUM_W + 10;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // one result transaction
   typedef struct packed {
      logic [CODE_W-1:0] lbp_code;
      logic              frame_end;
   } result_type;

   // neighbour masks travelling with an item
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } nbr_flags_type;

   // gray level as the floor of the mean of three components
   function automatic logic [GRAY_W-1:0] gray_of(input logic [COLOR_W-1:0] red,
                                                 input logic [COLOR_W-1:0] green,
                                                 input logic [COLOR_W-1:0] blue);
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] prod;
      sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
      prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
      return prod[DIV3_SHIFT +: GRAY_W];
   endfunction

endpackage

/* src/rgb_to_lbp_3x3_stream_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_lbp_3x3_stream_unit
// Raster rgb pixels in, 3x3 local binary pattern codes out.
// ----------------------------------------------------------------------------
// The unit accepts one pixel transaction per clock while the output queue has
// room, and keeps pace with a pixel stream. Each pixel is reduced to gray and
// stored in a line memory of MAX_WIDTH entries that holds the two previous
// rows side by side; the entry of the current column is read when the pixel
// is accepted and written back in the next cycle, so the single read and
// single write port of that memory set the rate of one pixel per cycle. The
// pattern of a pixel leaves once frame_width + 1 further transactions have
// come in, through the second stage and a small output queue that lets the
// input run on while a result waits. After the last pixel, frame_width + 1
// transactions with drain set flush the remaining patterns; frame_end marks the
// pattern of the last pixel. A configuration write restarts the frame.
`timescale 1ns / 1ps

module rgb_to_lbp_3x3_stream_unit
   import rgblbp_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COLOR_W-1:0]     req_red,
   input  logic [COLOR_W-1:0]     req_green,
   input  logic [COLOR_W-1:0]     req_blue,
   input  logic                   req_drain,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CODE_W-1:0]      rsp_lbp_code,
   output logic                   rsp_frame_end,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W = ((COL_W > FWIDTH_W) ? COL_W : FWIDTH_W) + 1;
   localparam int HCMP_W = IN_ROW_W + 1;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;
   localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WIDTH);

   // configuration registers
   logic [FWIDTH_W-1:0]  fwidth_ff;
   logic [FHEIGHT_W-1:0] fheight_ff;

   // stream counters
   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [FHEIGHT_W-1:0] out_row_ff, out_row_in;

   // second stage
   logic                 s1_valid_ff;
   logic                 s1_emit_ff;
   nbr_flags_type        s1_flags_ff;
   logic [GRAY_W-1:0]    s1_gray_ff;
   logic [COL_W-1:0]     s1_ix_ff;

   // line memory: {row above, current row} per column
   logic [2*GRAY_W-1:0]  line_mem [MAX_WIDTH];
   logic [2*GRAY_W-1:0]  mem_rd_ff;
   logic                 fwd_hit_ff;
   logic [2*GRAY_W-1:0]  fwd_data_ff;

   // 3x3 window, [row][col], row 0 top, col 0 left
   logic [GRAY_W-1:0]    win_ff [3][3];
   logic [GRAY_W-1:0]    win_in [3][3];

   // output queue
   result_type           q_mem [Q_DEPTH];
   logic [Q_PTR_W-1:0]   q_wr_ff, q_rd_ff;
   logic [Q_CNT_W-1:0]   q_cnt_ff;

   logic                 accept, flushing, launch, emit, pop, push;
   logic [GRAY_W-1:0]    gray;
   nbr_flags_type        flags;
   logic [CMP_W-1:0]     w_ext, in_col_nx, out_col_nx;
   logic [HCMP_W-1:0]    h_ext, out_row_nx;
   logic [2*GRAY_W-1:0]  rd_data, wr_data;
   logic [GRAY_W-1:0]    above_rd, cur_rd, center;
   logic [CODE_W-1:0]    code;
   logic [FWIDTH_W-1:0]  csr_w;
   logic [FHEIGHT_W-1:0] csr_h;

   // handshake
   assign accept    = req_valid && req_ready;
   assign req_ready = (q_cnt_ff + Q_CNT_W'(s1_valid_ff && s1_emit_ff)) <= Q_CNT_W'(2);
   assign pop       = rsp_valid && rsp_ready;
   assign push      = s1_valid_ff && s1_emit_ff;

   // first stage: gray, counters and neighbour masks
   always_comb begin
      w_ext      = CMP_W'(fwidth_ff);
      h_ext      = HCMP_W'(fheight_ff);
      flushing   = HCMP_W'(in_row_ff) >= h_ext;
      launch     = accept && !(req_drain && !flushing);
      gray       = flushing ? '0 : gray_of(req_red, req_green, req_blue);
      emit       = (in_row_ff >= IN_ROW_W'(2)) ||
                   ((in_row_ff == IN_ROW_W'(1)) && (in_col_ff != '0));
      in_col_nx  = CMP_W'(in_col_ff) + CMP_W'(1);
      out_col_nx = CMP_W'(out_col_ff) + CMP_W'(1);
      out_row_nx = HCMP_W'(out_row_ff) + HCMP_W'(1);
      flags.top    = out_row_ff != '0;
      flags.bottom = out_row_nx < h_ext;
      flags.left   = out_col_ff != '0;
      flags.right  = out_col_nx < w_ext;
      flags.last   = !flags.right && !flags.bottom;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (launch) begin
         if (in_col_nx >= w_ext) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IN_ROW_W'(1);
         end else begin
            in_col_in = in_col_nx[COL_W-1:0];
         end
         if (emit) begin
            if (flags.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (!flags.right) begin
               out_col_in = '0;
               out_row_in = out_row_nx[FHEIGHT_W-1:0];
            end else begin
               out_col_in = out_col_nx[COL_W-1:0];
            end
         end
      end
   end

   // configuration clamp
   always_comb begin
      csr_w = csr_data[FWIDTH_W-1:0];
      if (csr_w < FWIDTH_W'(2)) begin
         csr_w = FWIDTH_W'(2);
      end else if (CMP_W'(csr_w) > MAXW_C) begin
         csr_w = FWIDTH_W'(MAX_WIDTH);
      end
      csr_h = csr_data[FHEIGHT_W-1:0];
      if (csr_h < FHEIGHT_W'(2)) begin
         csr_h = FHEIGHT_W'(2);
      end
   end

   // configuration and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fwidth_ff  <= FWIDTH_W'(RESET_FRAME_WIDTH);
         fheight_ff <= FHEIGHT_W'(RESET_FRAME_HEIGHT);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  fwidth_ff  <= csr_w;
            CSR_FRAME_HEIGHT: fheight_ff <= csr_h;
            default: ;
         endcase
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // second stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= launch;
      end
   end

   // second stage payload and forwarding of a write to the entry being read
   always_ff @(posedge clock) begin
      if (launch) begin
         s1_emit_ff  <= emit;
         s1_flags_ff <= flags;
         s1_gray_ff  <= gray;
         s1_ix_ff    <= in_col_ff;
         fwd_hit_ff  <= s1_valid_ff && (s1_ix_ff == in_col_ff);
         fwd_data_ff <= wr_data;
      end
   end

   // line memory read and write back
   always_ff @(posedge clock) begin
      if (launch) begin
         mem_rd_ff <= line_mem[in_col_ff];
      end
      if (s1_valid_ff) begin
         line_mem[s1_ix_ff] <= wr_data;
      end
   end

   // window shift and pattern bits
   always_comb begin
      rd_data  = fwd_hit_ff ? fwd_data_ff : mem_rd_ff;
      above_rd = rd_data[2*GRAY_W-1:GRAY_W];
      cur_rd   = rd_data[GRAY_W-1:0];
      wr_data  = {cur_rd, s1_gray_ff};
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = above_rd;
      win_in[1][2] = cur_rd;
      win_in[2][2] = s1_gray_ff;
      center = win_in[1][1];
      code[7] = s1_flags_ff.top && (win_in[0][1] > center);
      code[6] = s1_flags_ff.top && s1_flags_ff.right && (win_in[0][2] > center);
      code[5] = s1_flags_ff.right && (win_in[1][2] > center);
      code[4] = s1_flags_ff.bottom && s1_flags_ff.right && (win_in[2][2] > center);
      code[3] = s1_flags_ff.bottom && (win_in[2][1] > center);
      code[2] = s1_flags_ff.bottom && s1_flags_ff.left && (win_in[2][0] > center);
      code[1] = s1_flags_ff.left && (win_in[1][0] > center);
      code[0] = s1_flags_ff.top && s1_flags_ff.left && (win_in[0][0] > center);
   end

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // output queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (push) begin
            q_wr_ff <= q_wr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            q_rd_ff <= q_rd_ff + Q_PTR_W'(1);
         end
         q_cnt_ff <= q_cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
      end
   end

   // output queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[q_wr_ff] <= '{lbp_code: code, frame_end: s1_flags_ff.last};
      end
   end

   assign rsp_valid     = q_cnt_ff != '0;
   assign rsp_lbp_code  = q_mem[q_rd_ff].lbp_code;
   assign rsp_frame_end = q_mem[q_rd_ff].frame_end;

   // queue never overflows
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (q_cnt_ff < Q_CNT_W'(Q_DEPTH)))
      else $error("output queue overflow");

   // a drain transaction inside the frame launches nothing
   a_drain_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && req_drain && !flushing) |=> !s1_valid_ff)
      else $error("drain inside frame reached second stage");

   // a write to the entry read in the same cycle is always forwarded
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (launch && s1_valid_ff && (s1_ix_ff == in_col_ff)) |=> fwd_hit_ff)
      else $error("missed forwarding of line memory write");

   // the pattern released by a transaction accepted alone while the queue was empty shows up
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (launch && emit && !s1_valid_ff && (q_cnt_ff == '0) && !csr_write)
      |=> ##1 rsp_valid)
      else $error("result did not reach output");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rgb to lbp 3x3 stream unit.
// ----------------------------------------------------------------------------
// Pixel transactions go in with random bursts and gaps while the result side
// stalls on its own changing pattern. A scoreboard class keeps its own line
// memories, 3x3 neighborhood and raster counters, predicts the pattern that
// every accepted transaction releases, and checks results in order. The run
// covers clamped register writes, frames abandoned by a write, drains inside a
// frame, pixels during the flush, random small frames and partial frames at
// the widest and tallest geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import rgblbp_pkg::*;
();

   localparam int RANDOM_ITEMS  = 220;
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT_NS  = 15_000_000;

   // pattern predictor and in-order result checker
   class lbp_scoreboard;
      logic [GRAY_W-1:0] row_above_mem [0:DEF_MAX_WIDTH-1];
      logic [GRAY_W-1:0] row_current_mem [0:DEF_MAX_WIDTH-1];
      logic [GRAY_W-1:0] nbhd [0:2][0:2];
      int unsigned pix_col, pix_row, code_col, code_row;
      int unsigned frame_width, frame_height;
      int unsigned fail_count;
      result_type expected_patterns[$];

      function new();
         for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            row_above_mem[i]   = '0;
            row_current_mem[i] = '0;
         end
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               nbhd[r][c] = '0;
         pix_col      = 0;
         pix_row      = 0;
         code_col     = 0;
         code_row     = 0;
         frame_width  = RESET_FRAME_WIDTH;
         frame_height = RESET_FRAME_HEIGHT;
         fail_count   = 0;
      endfunction

      // register write: clamp and restart the frame
      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         int unsigned v;
         if (idx == CSR_FRAME_WIDTH) begin
            v = 32'(data[FWIDTH_W-1:0]);
            if (v < 2) v = 2;
            if (v > DEF_MAX_WIDTH) v = DEF_MAX_WIDTH;
            frame_width = v;
         end else begin
            v = 32'(data[FHEIGHT_W-1:0]);
            if (v < 2) v = 2;
            frame_height = v;
         end
         pix_col  = 0;
         pix_row  = 0;
         code_col = 0;
         code_row = 0;
      endfunction

      // accepted input transaction: shift the window, maybe release a pattern
      function void take_pixel(logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                               logic [COLOR_W-1:0] blue, logic drain);
         logic [GRAY_W-1:0] gray;
         logic [GRAY_W-1:0] centre;
         int unsigned col;
         bit flushing, emit, top, bottom, left, right, last;
         result_type res;
         flushing = pix_row >= frame_height;
         // a drain inside the frame is ignored
         if (drain && !flushing) return;
         gray = flushing ? '0 : GRAY_W'((int'(red) + int'(green) + int'(blue)) / 3);
         col = (pix_col >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : pix_col;
         for (int r = 0; r < 3; r++) begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
         end
         nbhd[0][2] = row_above_mem[col];
         nbhd[1][2] = row_current_mem[col];
         nbhd[2][2] = gray;
         row_above_mem[col]   = row_current_mem[col];
         row_current_mem[col] = gray;
         emit = pix_row >= 2 || (pix_row == 1 && pix_col >= 1);
         pix_col++;
         if (pix_col >= frame_width) begin
            pix_col = 0;
            pix_row++;
         end
         if (!emit) return;
         // neighbors outside the frame give zero
         top    = code_row != 0;
         bottom = code_row + 1 < frame_height;
         left   = code_col != 0;
         right  = code_col + 1 < frame_width;
         centre = nbhd[1][1];
         res.lbp_code = {top && nbhd[0][1] > centre,
                         top && right && nbhd[0][2] > centre,
                         right && nbhd[1][2] > centre,
                         bottom && right && nbhd[2][2] > centre,
                         bottom && nbhd[2][1] > centre,
                         bottom && left && nbhd[2][0] > centre,
                         left && nbhd[1][0] > centre,
                         top && left && nbhd[0][0] > centre};
         last = code_col + 1 >= frame_width && code_row + 1 >= frame_height;
         res.frame_end = last;
         expected_patterns.push_back(res);
         if (last) begin
            pix_col  = 0;
            pix_row  = 0;
            code_col = 0;
            code_row = 0;
         end else begin
            code_col++;
            if (code_col >= frame_width) begin
               code_col = 0;
               code_row++;
            end
         end
      endfunction

      // accepted result transaction against the oldest expected pattern
      function void check_pattern(logic [CODE_W-1:0] code, logic frame_end);
         result_type exp_res;
         if (expected_patterns.size() == 0) begin
            $error("unexpected pattern: lbp_code %02h frame_end %0b", code, frame_end);
            fail_count++;
            return;
         end
         exp_res = expected_patterns.pop_front();
         if (code !== exp_res.lbp_code) begin
            $error("lbp_code: expected %02h, actual %02h", exp_res.lbp_code, code);
            fail_count++;
         end
         if (frame_end !== exp_res.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", exp_res.frame_end, frame_end);
            fail_count++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [COLOR_W-1:0]     req_red = '0;
   logic [COLOR_W-1:0]     req_green = '0;
   logic [COLOR_W-1:0]     req_blue = '0;
   logic                   req_drain = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CODE_W-1:0]      rsp_lbp_code;
   logic                   rsp_frame_end;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   lbp_scoreboard sb;
   int unsigned   burst_left = 0;
   int unsigned   counted_items = 0;
   int unsigned   ready_mode = 0;
   int unsigned   ready_left = 0;

   rgb_to_lbp_3x3_stream_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_drain     (req_drain),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_lbp_code  (rsp_lbp_code),
      .rsp_frame_end (rsp_frame_end),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   // result side stalls: always ready, random, or a fixed duty pattern
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_left <= $urandom_range(16, 96);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_ready <= (ready_left % 5) < 2;
         end
      endcase
   end

   // observe register writes and both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) sb.write_register(csr_index_type'(csr_index), csr_data);
         if (req_valid && req_ready) sb.take_pixel(req_red, req_green, req_blue, req_drain);
         if (rsp_valid && rsp_ready) sb.check_pattern(rsp_lbp_code, rsp_frame_end);
      end
   end

   // one input transaction, with a random gap at the start of each burst
   task automatic send_item(input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                            input logic [COLOR_W-1:0] blue, input logic drain);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      req_drain <= drain;
      do @(posedge clock); while (!req_ready);
   endtask

   // random pixel, often a flat gray to get equal neighbors
   task automatic send_random_pixel();
      logic [COLOR_W-1:0] r, g, b;
      if ($urandom_range(0, 2) == 0) begin
         r = COLOR_W'($urandom_range(0, 3) * 85);
         g = r;
         b = r;
      end else begin
         r = COLOR_W'($urandom_range(0, 255));
         g = COLOR_W'($urandom_range(0, 255));
         b = COLOR_W'($urandom_range(0, 255));
      end
      send_item(r, g, b, 1'b0);
   endtask

   task automatic send_drain();
      send_item(COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                COLOR_W'($urandom_range(0, 255)), 1'b1);
   endtask

   // stop sending and wait until every expected pattern has come out
   task automatic wait_for_patterns();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_patterns.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, block idle
   task automatic set_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // pixels of one frame with stray drains, then the flush if complete
   task automatic send_frame(input int unsigned pixel_total, input bit complete,
                             input bit pause_midway);
      int unsigned flush_total;
      flush_total = sb.frame_width + 1;
      for (int unsigned i = 0; i < pixel_total; i++) begin
         if ($urandom_range(0, 15) == 0) send_drain();
         if (pause_midway && i == pixel_total / 2) wait_for_patterns();
         send_random_pixel();
      end
      counted_items += pixel_total;
      if (!complete) return;
      // a pixel during the flush acts as a drain
      for (int unsigned i = 0; i < flush_total; i++) begin
         if ($urandom_range(0, 3) == 0) send_random_pixel();
         else send_drain();
      end
      counted_items += flush_total;
      // a drain after the frame end is ignored
      if ($urandom_range(0, 3) == 0) send_drain();
   endtask

   // stimulus
   initial begin
      int unsigned frame_no;
      int unsigned pixel_total;
      bit reconfigure;
      bit abandon;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // partial first row at reset geometry, no pattern yet, abandoned by a write
      send_frame(40, 1'b0, 1'b0);
      wait_for_patterns();

      // smallest frame through clamped writes, extreme colors
      set_register(CSR_FRAME_WIDTH, 12'h000);
      set_register(CSR_FRAME_HEIGHT, 12'h001);
      send_item(8'd255, 8'd255, 8'd255, 1'b0);
      send_item(8'd0, 8'd0, 8'd1, 1'b0);
      send_item(8'd9, 8'd9, 8'd9, 1'b1);
      send_item(8'd255, 8'd254, 8'd255, 1'b0);
      send_item(8'd1, 8'd0, 8'd0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b1);
      send_item(8'd7, 8'd7, 8'd7, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 1'b1);
      send_item(8'd0, 8'd0, 8'd0, 1'b1);
      wait_for_patterns();

      // 3x3 frame, dark center below every neighbor; width bit 11 is dropped
      set_register(CSR_FRAME_WIDTH, 12'h803);
      set_register(CSR_FRAME_HEIGHT, 12'd3);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_item(8'd0, 8'd0, 8'd2, 1'b0);
         else if (i % 2 == 0) send_item(8'd9, 8'd9, 8'd9, 1'b0);
         else send_item(8'd200, 8'd200, 8'd200, 1'b0);
      end
      for (int i = 0; i < 4; i++) send_item(8'd255, 8'd0, 8'd255, 1'b1);

      // random small frames, some abandoned, some back to back
      counted_items = 0;
      frame_no      = 0;
      reconfigure   = 1'b1;
      while (counted_items < RANDOM_ITEMS) begin
         if (reconfigure || $urandom_range(0, 3) == 0) begin
            wait_for_patterns();
            if (reconfigure || $urandom_range(0, 1) == 1)
               set_register(CSR_FRAME_WIDTH,
                            {1'($urandom_range(0, 1)), 11'($urandom_range(0, 9))});
            if ($urandom_range(0, 1) == 1)
               set_register(CSR_FRAME_HEIGHT, 12'($urandom_range(0, 6)));
         end
         pixel_total = sb.frame_width * sb.frame_height;
         abandon = ($urandom_range(0, 5) == 0);
         if (abandon) pixel_total = $urandom_range(1, pixel_total - 1);
         send_frame(pixel_total, !abandon, frame_no == 2);
         reconfigure = abandon;
         frame_no++;
      end
      wait_for_patterns();

      // start of the widest frame, then start of the tallest frame
      set_register(CSR_FRAME_WIDTH, 12'hFFF);
      set_register(CSR_FRAME_HEIGHT, 12'd2);
      send_frame(60, 1'b0, 1'b0);
      wait_for_patterns();
      set_register(CSR_FRAME_WIDTH, 12'd2);
      set_register(CSR_FRAME_HEIGHT, 12'hFFF);
      send_frame(80, 1'b0, 1'b0);
      wait_for_patterns();

      if (sb.expected_patterns.size() != 0) begin
         $error("%0d patterns never arrived", sb.expected_patterns.size());
         sb.fail_count++;
      end
      if (sb.fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
